### design/srd_pkg.sv
// Shared types, codes and constants of the scan reply decoder.
// Used by every module of the decoder; depends on nothing.
package srd_pkg;

  localparam int MAX_SCAN_READINGS = 1024;
  localparam int CNT_W = $clog2(MAX_SCAN_READINGS + 1);
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [6:0] STATUS_BAD_CHAR = 7'd99;
  localparam logic [3:0] ECHO_LEN_V1 = 4'd9;
  localparam logic [3:0] ECHO_LEN_V2 = 4'd12;
  localparam logic [1:0] VERSION_2 = 2'd2;

  typedef enum logic [1:0] {
    REG_PROTOCOL_VERSION = 2'd0,
    REG_FIRST_INDEX      = 2'd1,
    REG_LAST_INDEX       = 2'd2,
    REG_RANGE_LIMIT      = 2'd3
  } reg_index_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_BYTE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_READING = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    ERR_ECHO       = 2'd0,
    ERR_STATUS     = 2'd1,
    ERR_TOO_MANY   = 2'd2,
    ERR_OVER_RANGE = 2'd3
  } error_code_t;

  typedef struct packed {
    logic [1:0]  protocol_version;
    logic [9:0]  first_index;
    logic [10:0] last_index;
    logic [17:0] range_limit;
  } cfg_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [9:0]  reading_index;
    logic [17:0] reading_value;
    logic [10:0] reading_count;
    error_code_t error_code;
    logic [6:0]  sensor_status;
  } result_t;

  function automatic logic [7:0] echo_char_v1(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "G";
      4'd1:    c = "0";
      4'd2:    c = "0";
      4'd3:    c = "0";
      4'd4:    c = "7";
      4'd5:    c = "6";
      4'd6:    c = "8";
      4'd7:    c = "0";
      4'd8:    c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] echo_char_v2(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "G";
      4'd1:    c = "D";
      4'd2:    c = "0";
      4'd3:    c = "0";
      4'd4:    c = "0";
      4'd5:    c = "0";
      4'd6:    c = "0";
      4'd7:    c = "7";
      4'd8:    c = "6";
      4'd9:    c = "8";
      4'd10:   c = "0";
      4'd11:   c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic result_t stop_result(input error_code_t code, input logic [6:0] status,
                                          input logic [10:0] count);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.sensor_status = status;
    r.reading_count = count;
    return r;
  endfunction

endpackage

### design/srd_cfg_regs.sv
// Configuration register file of the scan reply decoder.
// Depends on srd_pkg for the register indexes and the cfg_t bundle.
module srd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [17:0]   cfg_data,
  output srd_pkg::cfg_t cfg
);
  import srd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= 2'd1;
      cfg.first_index      <= 10'd0;
      cfg.last_index       <= 11'd1024;
      cfg.range_limit      <= 18'd5600;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_PROTOCOL_VERSION: cfg.protocol_version <= cfg_data[1:0];
        REG_FIRST_INDEX:      cfg.first_index      <= cfg_data[9:0];
        REG_LAST_INDEX:       cfg.last_index       <= cfg_data[10:0];
        REG_RANGE_LIMIT:      cfg.range_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/srd_decoder.sv
// Input register and byte-wise reply parser of the scan reply decoder.
// Depends on srd_pkg; hands at most one result per request to srd_out_reg.
module srd_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tuser,
  input  logic [7:0]       s_tdata,
  input  srd_pkg::cfg_t    cfg,
  input  logic             out_space,
  output logic             res_valid,
  output srd_pkg::result_t res
);
  import srd_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ECHO   = 6'b000010,
    PH_STATUS = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_t;

  logic             in_valid;
  logic             in_type;
  logic [7:0]       in_byte;
  logic             advance;

  phase_t           phase, phase_next;
  logic [3:0]       echo_pos, echo_pos_next;
  logic [1:0]       lf_seen, lf_seen_next;
  logic [7:0]       held_char, held_char_next;
  logic             held_valid, held_valid_next;
  logic [17:0]      partial, partial_next;
  logic [1:0]       chars, chars_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic [CNT_W-1:0] em_cnt, em_cnt_next;
  logic [6:0]       status_value, status_value_next;
  logic             status_nonzero, status_nonzero_next;

  logic             v2;
  logic [3:0]       echo_len;
  logic [7:0]       echo_want;
  logic [1:0]       status_digits;
  logic [3:0]       st_digit;
  logic [7:0]       dc_char;
  logic [5:0]       dc_digit;
  logic [17:0]      dc_value;
  logic [1:0]       dc_chars;
  logic             dc_done;
  logic             idx_lo, idx_hi, idx_hi_incl;
  logic [CMP_W-1:0] idx_rel;
  logic [10:0]      count_out;
  logic             stop_now;
  logic             hit;

  assign advance  = in_valid && out_space;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  assign v2            = (cfg.protocol_version == VERSION_2);
  assign echo_len      = v2 ? ECHO_LEN_V2 : ECHO_LEN_V1;
  assign echo_want     = v2 ? echo_char_v2(echo_pos) : echo_char_v1(echo_pos);
  assign status_digits = v2 ? 2'd2 : 2'd1;
  assign st_digit      = 4'(in_byte - CHAR_ZERO);
  assign dc_char       = v2 ? held_char : in_byte;
  assign dc_digit      = 6'(dc_char - CHAR_ZERO);
  assign dc_value      = {partial[11:0], dc_digit};
  assign dc_chars      = chars + 2'd1;
  assign dc_done       = dc_chars >= (v2 ? 2'd3 : 2'd2);
  assign idx_lo        = rd_cnt >= cfg.first_index;
  assign idx_hi        = rd_cnt < cfg.last_index;
  assign idx_hi_incl   = rd_cnt <= cfg.last_index;
  assign idx_rel       = CMP_W'(rd_cnt) - CMP_W'(cfg.first_index);
  assign count_out     = 11'(em_cnt);

  always_comb begin
    phase_next          = phase;
    echo_pos_next       = echo_pos;
    lf_seen_next        = lf_seen;
    held_char_next      = held_char;
    held_valid_next     = held_valid;
    partial_next        = partial;
    chars_next          = chars;
    rd_cnt_next         = rd_cnt;
    em_cnt_next         = em_cnt;
    status_value_next   = status_value;
    status_nonzero_next = status_nonzero;
    res                 = '0;
    hit                 = 1'b0;
    stop_now            = 1'b0;
    if (advance) begin
      if (req_type_t'(in_type) == REQ_START) begin
        phase_next          = PH_ECHO;
        echo_pos_next       = 4'd0;
        lf_seen_next        = 2'd0;
        held_char_next      = 8'd0;
        held_valid_next     = 1'b0;
        partial_next        = 18'd0;
        chars_next          = 2'd0;
        rd_cnt_next         = '0;
        em_cnt_next         = '0;
        status_value_next   = 7'd0;
        status_nonzero_next = 1'b0;
      end else begin
        case (phase)
          PH_ECHO: begin
            if (echo_pos < echo_len) begin
              if (in_byte != echo_want) begin
                res = stop_result(ERR_ECHO, 7'd0, count_out);
                hit = 1'b1;
                phase_next = PH_STOP;
              end else begin
                echo_pos_next = echo_pos + 4'd1;
              end
            end else begin
              phase_next    = PH_STATUS;
              echo_pos_next = 4'd0;
            end
          end
          PH_STATUS: begin
            if (echo_pos < 4'(status_digits)) begin
              if (in_byte < CHAR_ZERO || in_byte > CHAR_NINE) begin
                status_nonzero_next = 1'b1;
                status_value_next   = STATUS_BAD_CHAR;
              end else begin
                if (in_byte != CHAR_ZERO) status_nonzero_next = 1'b1;
                if (status_value != STATUS_BAD_CHAR || echo_pos == 4'd0)
                  status_value_next = 7'(status_value * 7'd10) + 7'(st_digit);
              end
              echo_pos_next = echo_pos + 4'd1;
            end else if (status_nonzero) begin
              res = stop_result(ERR_STATUS, status_value, count_out);
              hit = 1'b1;
              phase_next = PH_STOP;
            end else begin
              echo_pos_next = 4'd0;
              lf_seen_next  = v2 ? 2'd0 : 2'd1;
              phase_next    = v2 ? PH_SKIP : PH_DATA;
            end
          end
          PH_SKIP: begin
            if (in_byte == CHAR_LF) begin
              if (lf_seen != 2'd0) begin
                lf_seen_next = 2'd1;
                phase_next   = PH_DATA;
              end else begin
                lf_seen_next = 2'd1;
              end
            end
          end
          PH_DATA: begin
            if (in_byte == CHAR_LF) begin
              if (lf_seen != 2'd0) begin
                res.kind          = KIND_DONE;
                res.reading_count = count_out;
                hit = 1'b1;
                phase_next = PH_STOP;
              end else begin
                lf_seen_next    = 2'd1;
                held_valid_next = 1'b0;
              end
            end else begin
              lf_seen_next = 2'd0;
              if (!v2 || held_valid) begin
                if (!dc_done) begin
                  partial_next = dc_value;
                  chars_next   = dc_chars;
                end else begin
                  partial_next = 18'd0;
                  chars_next   = 2'd0;
                  if (rd_cnt >= CNT_W'(MAX_SCAN_READINGS)) begin
                    res = stop_result(ERR_TOO_MANY, 7'd0, count_out);
                    hit = 1'b1;
                    stop_now = 1'b1;
                  end else begin
                    rd_cnt_next = rd_cnt + 1'b1;
                    if (v2 && dc_value > cfg.range_limit && idx_lo && idx_hi_incl) begin
                      res = stop_result(ERR_OVER_RANGE, 7'd0, count_out);
                      res.reading_index = idx_rel[9:0];
                      res.reading_value = dc_value;
                      hit = 1'b1;
                      stop_now = 1'b1;
                    end else if (idx_lo && idx_hi) begin
                      res.kind          = KIND_READING;
                      res.reading_index = idx_rel[9:0];
                      res.reading_value = dc_value;
                      hit = 1'b1;
                      em_cnt_next = em_cnt + 1'b1;
                    end
                  end
                end
              end
              if (stop_now) begin
                phase_next = PH_STOP;
              end else if (v2) begin
                held_char_next  = in_byte;
                held_valid_next = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_valid = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      echo_pos       <= 4'd0;
      lf_seen        <= 2'd0;
      held_char      <= 8'd0;
      held_valid     <= 1'b0;
      partial        <= 18'd0;
      chars          <= 2'd0;
      rd_cnt         <= '0;
      em_cnt         <= '0;
      status_value   <= 7'd0;
      status_nonzero <= 1'b0;
    end else begin
      phase          <= phase_next;
      echo_pos       <= echo_pos_next;
      lf_seen        <= lf_seen_next;
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;
      partial        <= partial_next;
      chars          <= chars_next;
      rd_cnt         <= rd_cnt_next;
      em_cnt         <= em_cnt_next;
      status_value   <= status_value_next;
      status_nonzero <= status_nonzero_next;
    end
  end

  a_emitted_le_read: assert property (@(posedge clk) disable iff (rst)
    em_cnt <= rd_cnt)
    else $error("emitted count passed reading count");

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != KIND_READING |=> phase == PH_STOP)
    else $error("completion or error did not stop the scan");

  a_held_in_data: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (phase == PH_DATA || phase == PH_STOP))
    else $error("held character outside data phase");

endmodule

### design/srd_out_reg.sv
// Result register of the scan reply decoder; drives the master stream.
// Depends on srd_pkg for result_t.
module srd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  srd_pkg::result_t res,
  output logic             out_space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [1:0]       m_tuser,
  output logic [47:0]      m_tdata
);
  import srd_pkg::*;

  result_t held;

  assign out_space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign m_tuser = held.kind;
  assign m_tdata = {held.sensor_status, held.error_code, held.reading_count,
                    held.reading_value, held.reading_index};

endmodule

### design/scan_reply_decoder_core.sv
// Scan reply decoder: parses a range-finder scan reply one byte per request
// (tuser 0 starts a scan, tuser 1 carries a reply byte) and streams out
// readings, a completion or an error stop. One request is taken every cycle
// while the result register can take a result; a request that yields a result
// passes the input register and then the result register. Intake pauses only while a
// result sits in the result register unclaimed. Write configuration only
// while no request is in flight.
module scan_reply_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [9:0] reading_index, [27:10] reading_value,
                                 // [38:28] reading_count, [40:39] error_code,
                                 // [47:41] sensor_status
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import srd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    out_space;

  srd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srd_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg       (cfg),
    .out_space (out_space),
    .res_valid (res_valid),
    .res       (res)
  );

  srd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_space (out_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for scan_reply_decoder_core: drives scan replies in both
// protocol versions with flawed variants, predicts every reading, completion and
// error stop, and compares them with the result stream. Depends on srd_pkg.
`timescale 1ns / 1ps

module testbench;
  import srd_pkg::*;

  localparam int PERIOD         = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int QUIET_LIMIT    = 5000;
  localparam int ITEM_TARGET    = 1650;

  localparam logic [8*9-1:0]  ECHO_TEXT_V1 = "G00076801";
  localparam logic [8*12-1:0] ECHO_TEXT_V2 = "GD0000076801";

  typedef enum logic [2:0] {
    P_IDLE, P_ECHO, P_STATUS, P_SKIP, P_DATA, P_STOP
  } scan_phase_t;

  typedef enum {
    FLAW_NONE, FLAW_ECHO, FLAW_STATUS, FLAW_BAD_CHAR, FLAW_NOISE, FLAW_CUT, FLAW_PARTIAL
  } flaw_t;

  class reply_scoreboard;
    cfg_t        cfg;
    scan_phase_t phase;
    int          echo_pos, lf_seen, n_chars, n_readings, n_emitted, status;
    bit          status_bad, held_ok;
    logic [7:0]  held;
    logic [17:0] partial;
    result_t     scan_outputs[$];
    int          errors;

    function new();
      cfg.protocol_version = 2'd1;
      cfg.first_index = 10'd0;
      cfg.last_index = 11'd1024;
      cfg.range_limit = 18'd5600;
      errors = 0;
      restart();
      phase = P_IDLE;
    endfunction

    function bit is_v2();
      return cfg.protocol_version == VERSION_2;
    endfunction

    function logic [7:0] echo_char(bit v2, int pos);
      if (v2) return ECHO_TEXT_V2[8*(11-pos) +: 8];
      return ECHO_TEXT_V1[8*(8-pos) +: 8];
    endfunction

    function void restart();
      phase = P_ECHO;
      echo_pos = 0;
      lf_seen = 0;
      held = '0;
      held_ok = 0;
      partial = '0;
      n_chars = 0;
      n_readings = 0;
      n_emitted = 0;
      status = 0;
      status_bad = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [17:0] val);
      case (idx)
        REG_PROTOCOL_VERSION: cfg.protocol_version = val[1:0];
        REG_FIRST_INDEX:      cfg.first_index = val[9:0];
        REG_LAST_INDEX:       cfg.last_index = val[10:0];
        REG_RANGE_LIMIT:      cfg.range_limit = val[17:0];
        default: ;
      endcase
    endfunction

    function result_t stop_with(error_code_t code, int stat);
      result_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.reading_count = n_emitted[10:0];
      r.error_code = code;
      r.sensor_status = stat[6:0];
      phase = P_STOP;
      return r;
    endfunction

    function bit take_char(logic [7:0] c, output result_t r);
      int need, idx, rel;
      logic [7:0] d;
      logic [17:0] val;
      r = '0;
      need = is_v2() ? 3 : 2;
      d = c - CHAR_ZERO;
      partial = {partial[11:0], d[5:0]};
      n_chars++;
      if (n_chars < need) return 0;
      val = partial;
      partial = '0;
      n_chars = 0;
      idx = n_readings;
      if (idx >= MAX_SCAN_READINGS) begin
        r = stop_with(ERR_TOO_MANY, 0);
        return 1;
      end
      n_readings++;
      rel = idx - cfg.first_index;
      if (is_v2() && val > cfg.range_limit && idx >= cfg.first_index &&
          idx <= cfg.last_index) begin
        r = stop_with(ERR_OVER_RANGE, 0);
        r.reading_index = rel[9:0];
        r.reading_value = val;
        return 1;
      end
      if (idx >= cfg.first_index && idx < cfg.last_index) begin
        r.kind = KIND_READING;
        r.reading_index = rel[9:0];
        r.reading_value = val;
        n_emitted++;
        return 1;
      end
      return 0;
    endfunction

    function bit decode_byte(logic typ, logic [7:0] b, output result_t r);
      int elen, digits;
      bit got;
      r = '0;
      elen = is_v2() ? 12 : 9;
      if (typ == REQ_START) begin
        restart();
        return 0;
      end
      case (phase)
        P_ECHO: begin
          if (echo_pos < elen) begin
            if (b != echo_char(is_v2(), echo_pos)) begin
              r = stop_with(ERR_ECHO, 0);
              return 1;
            end
            echo_pos++;
          end else begin
            phase = P_STATUS;
            echo_pos = 0;
          end
          return 0;
        end
        P_STATUS: begin
          digits = is_v2() ? 2 : 1;
          if (echo_pos < digits) begin
            if (b < CHAR_ZERO || b > CHAR_NINE) begin
              status_bad = 1;
              status = STATUS_BAD_CHAR;
            end else begin
              if (b != CHAR_ZERO) status_bad = 1;
              if (status != STATUS_BAD_CHAR || echo_pos == 0)
                status = status * 10 + (b - CHAR_ZERO);
            end
            echo_pos++;
            return 0;
          end
          if (status_bad) begin
            r = stop_with(ERR_STATUS, status);
            return 1;
          end
          echo_pos = 0;
          lf_seen = is_v2() ? 0 : 1;
          phase = is_v2() ? P_SKIP : P_DATA;
          return 0;
        end
        P_SKIP: begin
          if (b == CHAR_LF) begin
            lf_seen++;
            if (lf_seen >= 2) begin
              lf_seen = 1;
              phase = P_DATA;
            end
          end
          return 0;
        end
        P_DATA: begin
          if (b == CHAR_LF) begin
            if (lf_seen != 0) begin
              r.kind = KIND_DONE;
              r.reading_count = n_emitted[10:0];
              phase = P_STOP;
              return 1;
            end
            lf_seen = 1;
            held_ok = 0;
            return 0;
          end
          lf_seen = 0;
          if (!is_v2()) return take_char(b, r);
          // drop the last character of each line: it is the checksum
          got = 0;
          if (held_ok) got = take_char(held, r);
          if (phase == P_DATA) begin
            held = b;
            held_ok = 1;
          end
          return got;
        end
        default: return 0;
      endcase
    endfunction

    function void note_request(logic typ, logic [7:0] b);
      result_t r;
      if (decode_byte(typ, b, r)) scan_outputs.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check(result_t got);
      result_t want;
      if (scan_outputs.size() == 0) begin
        report("unexpected result, out_kind", got.kind, 0);
        return;
      end
      want = scan_outputs.pop_front();
      if (got.kind !== want.kind) report("out_kind", got.kind, want.kind);
      if (got.reading_index !== want.reading_index)
        report("reading_index", got.reading_index, want.reading_index);
      if (got.reading_value !== want.reading_value)
        report("reading_value", got.reading_value, want.reading_value);
      if (got.reading_count !== want.reading_count)
        report("reading_count", got.reading_count, want.reading_count);
      if (got.error_code !== want.error_code)
        report("error_code", got.error_code, want.error_code);
      if (got.sensor_status !== want.sensor_status)
        report("sensor_status", got.sensor_status, want.sensor_status);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [17:0] cfg_data = 18'd0;

  reply_scoreboard sb = new();
  result_t observed;
  int  sent = 0;
  int  quiet_cycles = 0;
  bit  tx_calm = 0;
  bit  squeeze_req = 0;
  bit  squeeze_done = 0;

  scan_reply_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [17:0] pick_value(bit v2);
    int r;
    r = $urandom_range(0, 99);
    if (!v2) begin
      if (r < 10) return 18'd0;
      if (r < 20) return 18'hFFF;
      return 18'($urandom_range(0, 4095));
    end
    if (r < 8) return 18'd0;
    if (r < 10) return 18'h3FFFF;
    if (r < 13) return 18'($urandom_range(0, 262143));
    return 18'($urandom_range(0, sb.cfg.range_limit));
  endfunction

  task send_req(input logic typ, input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= typ;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(typ, b);
    sent++;
  endtask

  task put_reg(input reg_index_t idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task write_regs(input logic [1:0] ver, input logic [9:0] fi, input logic [10:0] li,
                  input logic [17:0] rl);
    put_reg(REG_PROTOCOL_VERSION, 18'(ver));
    put_reg(REG_FIRST_INDEX, 18'(fi));
    put_reg(REG_LAST_INDEX, 18'(li));
    put_reg(REG_RANGE_LIMIT, rl);
    cfg_valid <= 1'b0;
  endtask

  task settle();
    s_tvalid <= 1'b0;
    while (sb.scan_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task close_line(input bit v2);
    if (v2) send_req(REQ_BYTE, 8'($urandom_range(8'h30, 8'h6F)));
    send_req(REQ_BYTE, CHAR_LF);
  endtask

  task automatic run_scan(input int n_read, input flaw_t flaw);
    logic [7:0]  chars[$];
    logic [7:0]  c;
    logic [17:0] val;
    int elen, need, digits, bad_pos, line_len, in_line, cut_at, k, j;
    bit v2;
    v2 = sb.is_v2();
    elen = v2 ? 12 : 9;
    need = v2 ? 3 : 2;
    digits = v2 ? 2 : 1;
    bad_pos = (flaw == FLAW_ECHO) ? $urandom_range(0, elen - 1) : elen;
    send_req(REQ_START, 8'($urandom_range(0, 255)));
    for (k = 0; k < elen; k++) begin
      c = sb.echo_char(v2, k);
      if (k == bad_pos) c = c ^ 8'($urandom_range(1, 255));
      send_req(REQ_BYTE, c);
    end
    send_req(REQ_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LF);
    for (k = 0; k < digits; k++) begin
      if (flaw == FLAW_STATUS)
        c = CHAR_ZERO + 8'($urandom_range(0, 9));
      else if (flaw == FLAW_BAD_CHAR && k == 0)
        c = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h2F))
                                 : 8'($urandom_range(8'h3A, 8'hFF));
      else if (flaw == FLAW_BAD_CHAR)
        c = 8'($urandom_range(0, 255));
      else
        c = CHAR_ZERO;
      send_req(REQ_BYTE, c);
    end
    if ($urandom_range(0, 3) == 0)
      send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
    else
      send_req(REQ_BYTE, v2 ? 8'($urandom_range(8'h30, 8'h6F)) : CHAR_LF);
    if (v2) begin
      send_req(REQ_BYTE, CHAR_LF);
      repeat (4) send_req(REQ_BYTE, 8'($urandom_range(8'h30, 8'h6F)));
      close_line(1'b1);
    end
    repeat (n_read) begin
      val = pick_value(v2);
      for (j = need - 1; j >= 0; j--)
        chars.push_back(CHAR_ZERO + 8'((val >> (6 * j)) & 18'h3F));
    end
    if (flaw == FLAW_PARTIAL)
      repeat ($urandom_range(1, need - 1))
        chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 63)));
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(0, chars.size()) : -1;
    line_len = $urandom_range(1, 64);
    in_line = 0;
    for (k = 0; k < chars.size(); k++) begin
      if (k == cut_at) return;
      if (flaw == FLAW_NOISE && $urandom_range(0, 15) == 0)
        send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
      send_req(REQ_BYTE, chars[k]);
      in_line++;
      if (in_line == line_len) begin
        close_line(v2);
        in_line = 0;
        line_len = $urandom_range(1, 64);
      end
    end
    if (flaw == FLAW_CUT) return;
    if (in_line > 0) close_line(v2);
    send_req(REQ_BYTE, CHAR_LF);
  endtask

  initial begin
    int g;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        // hold off the result side long enough for the block to back up
        m_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      observed.kind = out_kind_t'(m_tuser);
      observed.reading_index = m_tdata[9:0];
      observed.reading_value = m_tdata[27:10];
      observed.reading_count = m_tdata[38:28];
      observed.error_code = error_code_t'(m_tdata[40:39]);
      observed.sensor_status = m_tdata[47:41];
      sb.check(observed);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int target, phase_no, r, n, top;
    flaw_t flaw;
    logic [1:0]  ver;
    logic [9:0]  fi;
    logic [10:0] li;
    logic [17:0] rl;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // bytes before any start go nowhere
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'hFF);
    run_scan(2, FLAW_NONE);
    run_scan(0, FLAW_NONE);
    run_scan(1, FLAW_ECHO);
    run_scan(0, FLAW_BAD_CHAR);
    run_scan(2, FLAW_PARTIAL);
    run_scan(3, FLAW_CUT);
    settle();
    write_regs(VERSION_2, 10'd0, 11'd1024, 18'd5600);
    run_scan(2, FLAW_NONE);
    run_scan(0, FLAW_NONE);
    run_scan(1, FLAW_STATUS);
    run_scan(0, FLAW_BAD_CHAR);
    settle();
    write_regs(VERSION_2, 10'd1, 11'd2, 18'd0);
    run_scan(4, FLAW_NONE);

    target = ITEM_TARGET;
    phase_no = 0;
    while (sent < target) begin
      settle();
      if (phase_no == 0) begin
        write_regs(VERSION_2, 10'd1023, 11'd1024, 18'h3FFFF);
      end else if (phase_no == 1 || phase_no == 2) begin
        write_regs(2'd1, 10'd0, 11'd1024, 18'd5600);
      end else begin
        ver = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(1, 2));
        r = $urandom_range(0, 99);
        fi = (r < 40) ? 10'd0 : (r < 80) ? 10'($urandom_range(0, 40)) :
             (r < 95) ? 10'($urandom_range(0, 1023)) : 10'd1023;
        r = $urandom_range(0, 99);
        top = fi + $urandom_range(0, 30);
        if (top > 1024) top = 1024;
        li = (r < 30) ? 11'd1024 : (r < 85) ? 11'(top) : 11'd0;
        r = $urandom_range(0, 99);
        rl = (r < 15) ? 18'd0 : (r < 30) ? 18'h3FFFF : (r < 50) ? 18'd5600 :
             18'($urandom_range(0, 262143));
        write_regs(ver, fi, li, rl);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 1) begin
        squeeze_req = 1;
        tx_calm = 1;
        run_scan(90, FLAW_NONE);
      end
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 68) flaw = FLAW_NONE;
        else if (r < 76) flaw = FLAW_NOISE;
        else if (r < 82) flaw = FLAW_ECHO;
        else if (r < 87) flaw = FLAW_STATUS;
        else if (r < 90) flaw = FLAW_BAD_CHAR;
        else if (r < 95) flaw = FLAW_CUT;
        else flaw = FLAW_PARTIAL;
        n = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 16) : $urandom_range(17, 150);
        run_scan(n, flaw);
      end
      phase_no++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### scan_reply_decoder_core.f
design/srd_pkg.sv
design/srd_cfg_regs.sv
design/srd_decoder.sv
design/srd_out_reg.sv
design/scan_reply_decoder_core.sv
tb/testbench.sv
